// File: rtl/cnmd_pkg.sv
`default_nettype none

package cnmd_pkg;

  // Fixed field widths of the streams and the side register
  localparam int PIX_W  = 8;
  localparam int SIDE_W = 11;

  localparam int MAX_SIDE_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int              SIDE_MIN   = 2;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  // Control of the item held in the memory read stage
  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  row0;    // first image row: store only, no result
    logic  border;  // copy the centre pixel
    logic  last;    // final result of the image
    logic  fwd;     // centre read hit the write of the item ahead
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: rtl/cross_neighbour_max_dilation.sv
`default_nettype none

// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid_i/tready_o       tdata: pixel_in; tuser: func
// m_axis    out        m_axis_tvalid_o/tready_i       tdata: pixel_out; tlast: last_out
// cfg       in         cfg_we_i                       cfg_wdata_i: image_side
//
// One item per cycle sustained. An accepted pixel reads the row memories in
// the accept cycle and writes them back in the cycle after; in that cycle its
// result also enters a three-entry output queue.
// The input stalls only while the output queue cannot absorb the item in
// flight. Reset clears the counters and the queue; the row memories need no
// clearing pass, since every entry is written before its value is used.
module cross_neighbour_max_dilation #(
  parameter int MAX_SIDE   = cnmd_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = cnmd_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cnmd_pkg::SIDE_W-1:0] cfg_wdata_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [cnmd_pkg::PIX_W-1:0]  s_axis_tdata_i,   // [7:0] pixel_in
  input  wire logic                        s_axis_tuser_i,   // [0] func
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic      [cnmd_pkg::PIX_W-1:0]  m_axis_tdata_o,   // [7:0] pixel_out
  output logic                             m_axis_tlast_o
);

  import cnmd_pkg::*;

  localparam int DW = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int AW = $clog2(MAX_SIDE);

  stage_ctl_t    b;
  logic [AW-1:0] b_col, c_raddr, u_raddr, c_waddr, u_waddr;
  logic [DW-1:0] b_pix, c_rdata, u_rdata, c_wdata, u_wdata;
  logic          c_re, u_re, c_we, u_we, push, can_take;
  logic [DW:0]   push_data, q_data;

  cnmd_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .DW       (DW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (can_take),
    .in_kind_i   (s_axis_tuser_i),
    .in_pix_i    (s_axis_tdata_i),
    .c_re_o      (c_re),
    .c_raddr_o   (c_raddr),
    .u_re_o      (u_re),
    .u_raddr_o   (u_raddr),
    .b_o         (b),
    .b_col_o     (b_col),
    .b_pix_o     (b_pix)
  );

  cnmd_ram #(
    .DW    (DW),
    .DEPTH (MAX_SIDE)
  ) u_centre_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  cnmd_ram #(
    .DW    (DW),
    .DEPTH (MAX_SIDE)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .re_i    (u_re),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  cnmd_dp #(
    .MAX_SIDE (MAX_SIDE),
    .DW       (DW)
  ) u_dp (
    .clk_i       (clk_i),
    .b_i         (b),
    .b_col_i     (b_col),
    .b_pix_i     (b_pix),
    .c_rdata_i   (c_rdata),
    .u_rdata_i   (u_rdata),
    .c_we_o      (c_we),
    .c_waddr_o   (c_waddr),
    .c_wdata_o   (c_wdata),
    .u_we_o      (u_we),
    .u_waddr_o   (u_waddr),
    .u_wdata_o   (u_wdata),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cnmd_outq #(
    .PW (DW + 1)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .can_take_o  (can_take),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (q_data)
  );

  assign s_axis_tready_o = can_take;
  assign m_axis_tdata_o  = PIX_W'(q_data[DW-1:0]);
  assign m_axis_tlast_o  = q_data[DW];

endmodule

`default_nettype wire

// File: rtl/cnmd_ram.sv
`default_nettype none

module cnmd_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/cnmd_ctrl.sv
`default_nettype none

module cnmd_ctrl #(
  parameter int MAX_SIDE = cnmd_pkg::MAX_SIDE_DEF,
  parameter int DW       = cnmd_pkg::PIX_W,
  localparam int AW      = $clog2(MAX_SIDE)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cnmd_pkg::SIDE_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic                          in_kind_i,
  input  wire logic [cnmd_pkg::PIX_W-1:0]    in_pix_i,
  output logic                               c_re_o,
  output logic      [AW-1:0]                 c_raddr_o,
  output logic                               u_re_o,
  output logic      [AW-1:0]                 u_raddr_o,
  output cnmd_pkg::stage_ctl_t               b_o,
  output logic      [AW-1:0]                 b_col_o,
  output logic      [DW-1:0]                 b_pix_o
);

  import cnmd_pkg::*;

  localparam int CW = $clog2(MAX_SIDE + 1);

  logic [SIDE_W-1:0] img_q, img_d;
  logic [CW-1:0]     side, side_m1, col_inc;
  logic [CW-1:0]     in_col_q, in_col_d, in_row_q, in_row_d, out_col_q, out_col_d;
  stage_ctl_t        b_q, b_d;
  logic [AW-1:0]     b_col_q, b_col_d;
  logic [DW-1:0]     b_pix_q, b_pix_d;
  logic              accept, at_end, pix_ok, drn_ok;

  // Clamp the side to the supported range
  always_comb begin
    if (img_q < SIDE_W'(SIDE_MIN)) begin
      side = CW'(SIDE_MIN);
    end else if (32'(img_q) > 32'(MAX_SIDE)) begin
      side = CW'(MAX_SIDE);
    end else begin
      side = CW'(img_q);
    end
  end

  assign side_m1 = CW'(side - 1'b1);
  assign col_inc = CW'(in_col_q + 1'b1);
  assign at_end  = (in_col_q == side_m1);
  assign pix_ok  = (in_row_q < side) && (in_col_q < side);
  assign drn_ok  = (in_row_q >= side) && (out_col_q < side);
  assign accept  = in_valid_i && in_ready_i;

  always_comb begin
    img_d     = img_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    b_d       = '0;
    b_col_d   = b_col_q;
    b_pix_d   = b_pix_q;
    c_re_o    = 1'b0;
    c_raddr_o = out_col_q[AW-1:0];
    u_re_o    = 1'b0;
    u_raddr_o = in_col_q[AW-1:0];

    if (cfg_we_i) begin
      img_d     = cfg_wdata_i;
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
    end else if (accept) begin
      if (kind_e'(in_kind_i) == KIND_PIXEL) begin
        if (pix_ok) begin
          // Fetch the centre pixel one column ahead; at row end wrap to column zero
          c_re_o    = 1'b1;
          c_raddr_o = at_end ? '0 : col_inc[AW-1:0];
          u_re_o    = 1'b1;
          b_d.valid  = 1'b1;
          b_d.kind   = KIND_PIXEL;
          b_d.row0   = (in_row_q == '0);
          b_d.border = (in_row_q == CW'(1)) || (in_col_q == '0) || at_end;
          b_col_d    = in_col_q[AW-1:0];
          b_pix_d    = in_pix_i[DW-1:0];
          if (in_row_q != '0) begin
            out_col_d = at_end ? '0 : col_inc;
          end
          if (at_end) begin
            in_col_d = '0;
            in_row_d = CW'(in_row_q + 1'b1);
          end else begin
            in_col_d = col_inc;
          end
        end
      end else if (drn_ok) begin
        c_re_o    = 1'b1;
        b_d.valid = 1'b1;
        b_d.kind  = KIND_DRAIN;
        b_d.last  = (out_col_q == side_m1);
        b_col_d   = out_col_q[AW-1:0];
        if (out_col_q == side_m1) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
        end else begin
          out_col_d = CW'(out_col_q + 1'b1);
        end
      end
    end

    // Centre read of the same entry the item ahead writes this cycle
    b_d.fwd = c_re_o && b_q.valid && (b_q.kind == KIND_PIXEL) && (c_raddr_o == b_col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q     <= SIDE_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      b_q       <= '0;
    end else begin
      img_q     <= img_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      b_q       <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_col_q <= b_col_d;
    b_pix_q <= b_pix_d;
  end

  assign b_o     = b_q;
  assign b_col_o = b_col_q;
  assign b_pix_o = b_pix_q;

endmodule

`default_nettype wire

// File: rtl/cnmd_dp.sv
`default_nettype none

module cnmd_dp #(
  parameter int MAX_SIDE = cnmd_pkg::MAX_SIDE_DEF,
  parameter int DW       = cnmd_pkg::PIX_W,
  localparam int AW      = $clog2(MAX_SIDE)
) (
  input  wire logic                  clk_i,
  input  wire cnmd_pkg::stage_ctl_t  b_i,
  input  wire logic [AW-1:0]         b_col_i,
  input  wire logic [DW-1:0]         b_pix_i,
  input  wire logic [DW-1:0]         c_rdata_i,
  input  wire logic [DW-1:0]         u_rdata_i,
  output logic                       c_we_o,
  output logic      [AW-1:0]         c_waddr_o,
  output logic      [DW-1:0]         c_wdata_o,
  output logic                       u_we_o,
  output logic      [AW-1:0]         u_waddr_o,
  output logic      [DW-1:0]         u_wdata_o,
  output logic                       push_o,
  output logic      [DW:0]           push_data_o
);

  import cnmd_pkg::*;

  logic [DW-1:0] mid_q, right_q, fwd_pix_q;
  logic [DW-1:0] cd, win_left, win_mid, win_right, m_a, m_b, m_max, result;
  logic          pix_go;

  assign pix_go = b_i.valid && (b_i.kind == KIND_PIXEL);
  assign cd     = b_i.fwd ? fwd_pix_q : c_rdata_i;

  // Cross window: left and centre come from earlier reads of the centre row
  assign win_left  = mid_q;
  assign win_mid   = right_q;
  assign win_right = cd;

  assign m_a    = (u_rdata_i > b_pix_i) ? u_rdata_i : b_pix_i;
  assign m_b    = (win_left > win_right) ? win_left : win_right;
  assign m_max  = (m_a > m_b) ? m_a : m_b;
  assign result = b_i.border ? win_mid : m_max;

  always_ff @(posedge clk_i) begin
    if (pix_go) begin
      mid_q     <= right_q;
      right_q   <= cd;
      fwd_pix_q <= b_pix_i;
    end
  end

  assign c_we_o    = pix_go;
  assign c_waddr_o = b_col_i;
  assign c_wdata_o = b_pix_i;
  assign u_we_o    = pix_go && !b_i.row0;
  assign u_waddr_o = b_col_i;
  assign u_wdata_o = win_mid;

  always_comb begin
    push_o      = 1'b0;
    push_data_o = {1'b0, result};
    if (b_i.valid) begin
      if (b_i.kind == KIND_DRAIN) begin
        push_o      = 1'b1;
        push_data_o = {b_i.last, cd};
      end else begin
        push_o = !b_i.row0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cnmd_outq.sv
`default_nettype none

module cnmd_outq #(
  parameter int PW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [PW-1:0] push_data_i,
  output logic               can_take_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic      [PW-1:0] data_o
);

  localparam int DEPTH = 3;

  logic [PW-1:0] buf_q [DEPTH];
  logic [1:0]    wr_q, wr_d, rd_q, rd_d, cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_q];
  assign pop     = valid_o && ready_i;

  // One item may still come out of the read stage after an accept
  assign can_take_o = (3'(cnt_q) + 3'(push_i)) <= 3'(DEPTH - 1);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == 2'(DEPTH - 1)) ? '0 : 2'(wr_q + 1'b1);
    end
    if (pop) begin
      rd_d = (rd_q == 2'(DEPTH - 1)) ? '0 : 2'(rd_q + 1'b1);
    end
    cnt_d = 2'(cnt_q + 2'(push_i) - 2'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire
